// File: sv/elsu_pkg.sv
`timescale 1ns / 1ps

package elsu_pkg;

  // Fixed field widths
  localparam int IDX_W      = 12;
  localparam int SIZE_W     = 2;
  localparam int ORD_W      = 2;
  localparam int DATA_W     = 64;
  localparam int BYTE_W     = 8;

  // Byte banking: one bank per byte lane of an eight-byte word
  localparam int NUM_BANKS  = 8;
  localparam int LANE_W     = 3;

  localparam int STORE_BYTES_DEF = 4096;

  // Configuration port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 2;
  localparam logic [APB_ADDR_W-1:0] ADDR_NATIVE_IS_BIG = '0;

  // Access kind
  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  // Byte order codes; the remaining codes mean native
  localparam logic [ORD_W-1:0] ORD_LITTLE = 2'd0;
  localparam logic [ORD_W-1:0] ORD_BIG    = 2'd1;

  // Control that travels with an item from the bank read to the read aligner
  typedef struct packed {
    logic              is_read;  // read that passed the range check
    logic              sgn;
    logic              big;
    logic [SIZE_W-1:0] size;
    logic [LANE_W-1:0] lane;     // bank of the lowest addressed byte
  } rd_ctl_t;

  // Number of bytes for a width code
  function automatic logic [LANE_W:0] byte_count(input logic [SIZE_W-1:0] size);
    return (LANE_W+1)'(1) << size;
  endfunction

  // Offset from the start address of the k-th least significant value byte
  function automatic logic [LANE_W-1:0] lane_pos(input logic big,
                                                 input logic [LANE_W:0] nbytes,
                                                 input logic [LANE_W-1:0] k);
    logic [LANE_W:0] rev;
    rev = nbytes - (LANE_W+1)'(k) - (LANE_W+1)'(1);
    return big ? rev[LANE_W-1:0] : k;
  endfunction

endpackage

// File: sv/elsu_bank.sv
`timescale 1ns / 1ps

module elsu_bank
  import elsu_pkg::*;
#(
  parameter int DEPTH  = STORE_BYTES_DEF / NUM_BANKS,
  parameter int ADDR_W = $clog2(STORE_BYTES_DEF / NUM_BANKS)
) (
  input  logic              clk,
  input  logic              acc_en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [BYTE_W-1:0] wdata,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_r;

  // One access per cycle; read data registered
  always_ff @(posedge clk) begin
    if (acc_en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/elsu_rd_align.sv
`timescale 1ns / 1ps

module elsu_rd_align
  import elsu_pkg::*;
(
  input  rd_ctl_t                          ctl,
  input  logic [NUM_BANKS-1:0][BYTE_W-1:0] bank_data,
  output logic [DATA_W-1:0]                value
);

  logic [LANE_W:0]   nbytes;
  logic [DATA_W-1:0] raw;
  logic              fill;

  assign nbytes = byte_count(ctl.size);

  // Gather value bytes from the banks in byte order
  always_comb begin
    logic [LANE_W-1:0] d;
    logic [LANE_W-1:0] bank;
    raw = '0;
    for (int k = 0; k < NUM_BANKS; k++) begin
      d    = lane_pos(ctl.big, nbytes, LANE_W'(k));
      bank = ctl.lane + d;
      if ((LANE_W+1)'(k) < nbytes) begin
        raw[k*BYTE_W +: BYTE_W] = bank_data[bank];
      end
    end
  end

  // Sign of the top value byte
  assign fill = ctl.sgn & raw[6'({nbytes, 3'b000} - 7'd1)];

  // Extend above the access width; zero for writes and rejected accesses
  always_comb begin
    value = '0;
    if (ctl.is_read) begin
      for (int k = 0; k < NUM_BANKS; k++) begin
        if ((LANE_W+1)'(k) < nbytes) begin
          value[k*BYTE_W +: BYTE_W] = raw[k*BYTE_W +: BYTE_W];
        end else begin
          value[k*BYTE_W +: BYTE_W] = {BYTE_W{fill}};
        end
      end
    end
  end

endmodule

// File: sv/endian_byte_load_store_unit_core.sv
`timescale 1ns / 1ps

// Byte-addressed load/store unit with selectable byte order.
// Input channel (in_valid/in_ready): one read or write per item, 1, 2, 4 or
// 8 bytes at any byte index, little, big or native order. Result channel
// (out_valid/out_ready): exactly one item per input item, in order, with the
// extended read value (zero on writes) and a range flag for accesses that
// run past the end of the store; such accesses write nothing.
// Configuration: APB register at address 0, bit 0 = native order is big.
// The store is split into eight byte banks, so any access, aligned or not,
// touches each bank at most once. An item passes the input register, then
// the bank read, then the result register before out_valid; throughput is
// one item per cycle while the receiver does not stall, set by the single
// access port of each bank. A read sees every earlier write.
// Reset clears the pipeline valid bits and the order register; the store
// contents are undefined until written. When the receiver stalls the
// result register holds, the stages behind it keep filling, and in_ready
// drops only when all three stages are occupied.

module endian_byte_load_store_unit_core
  import elsu_pkg::*;
#(
  parameter int STORE_BYTES = STORE_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_operation,
  input  logic [IDX_W-1:0]      in_byte_index,
  input  logic [SIZE_W-1:0]     in_access_size,
  input  logic                  in_is_signed,
  input  logic [ORD_W-1:0]      in_byte_order,
  input  logic [DATA_W-1:0]     in_write_value,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_W-1:0]     out_read_value,
  output logic                  out_range_error,

  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int NUM_ROWS   = (STORE_BYTES + NUM_BANKS - 1) / NUM_BANKS;
  localparam int ROW_W      = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int ROW_SUM_W  = (ROW_W > IDX_W - LANE_W + 1) ? ROW_W : IDX_W - LANE_W + 1;
  localparam int LIM_W      = $clog2(STORE_BYTES + 1);
  localparam int SUM_W      = (LIM_W > IDX_W + 1) ? LIM_W : IDX_W + 1;

  // Configuration register
  logic native_is_big_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      native_is_big_r <= 1'b0;
    end else if (psel && penable && pwrite && paddr == ADDR_NATIVE_IS_BIG) begin
      native_is_big_r <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_NATIVE_IS_BIG) ?
                  APB_DATA_W'(native_is_big_r) : '0;

  // Stage enables
  logic a_valid_r, b_valid_r, out_valid_r;
  logic en_a, en_b, en_c;

  assign en_c     = !out_valid_r || out_ready;
  assign en_b     = !b_valid_r || en_c;
  assign en_a     = !a_valid_r || en_b;
  assign in_ready = en_a;

  // Input register
  op_t               a_op_r;
  logic [IDX_W-1:0]  a_idx_r;
  logic [SIZE_W-1:0] a_size_r;
  logic              a_sgn_r;
  logic [ORD_W-1:0]  a_ord_r;
  logic [DATA_W-1:0] a_wval_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en_a) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_op_r   <= op_t'(in_operation);
      a_idx_r  <= in_byte_index;
      a_size_r <= in_access_size;
      a_sgn_r  <= in_is_signed;
      a_ord_r  <= in_byte_order;
      a_wval_r <= in_write_value;
    end
  end

  // Decode: width, order, range check
  logic [LANE_W:0]   a_nbytes;
  logic              a_big;
  logic              a_err;
  logic [LANE_W-1:0] a_lane;

  assign a_nbytes = byte_count(a_size_r);
  assign a_lane   = a_idx_r[LANE_W-1:0];
  assign a_err    = (SUM_W'(a_idx_r) + SUM_W'(a_nbytes)) > SUM_W'(STORE_BYTES);

  always_comb begin
    priority if (a_ord_r == ORD_LITTLE) begin
      a_big = 1'b0;
    end else if (a_ord_r == ORD_BIG) begin
      a_big = 1'b1;
    end else begin
      a_big = native_is_big_r;
    end
  end

  // Bank steering: row, write enable and write byte per bank
  logic                             bank_acc;
  logic [NUM_BANKS-1:0]             bank_we;
  logic [ROW_W-1:0]                 bank_row [NUM_BANKS];
  logic [NUM_BANKS-1:0][BYTE_W-1:0] bank_wdata;
  logic [NUM_BANKS-1:0][BYTE_W-1:0] bank_rdata;

  assign bank_acc = a_valid_r && en_b;

  always_comb begin
    logic [LANE_W-1:0]    d;
    logic [LANE_W-1:0]    k;
    logic [ROW_SUM_W-1:0] row_sum;
    for (int b = 0; b < NUM_BANKS; b++) begin
      d             = LANE_W'(b) - a_lane;
      k             = lane_pos(a_big, a_nbytes, d);
      row_sum       = ROW_SUM_W'(a_idx_r[IDX_W-1:LANE_W]) +
                      ROW_SUM_W'(LANE_W'(b) < a_lane);
      bank_row[b]   = row_sum[ROW_W-1:0];
      bank_wdata[b] = a_wval_r[{k, 3'b000} +: BYTE_W];
      bank_we[b]    = bank_acc && (a_op_r == OP_WRITE) && !a_err &&
                      ({1'b0, d} < a_nbytes);
    end
  end

  for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
    elsu_bank #(
      .DEPTH  (NUM_ROWS),
      .ADDR_W (ROW_W)
    ) u_bank (
      .clk    (clk),
      .acc_en (bank_acc),
      .we     (bank_we[g]),
      .addr   (bank_row[g]),
      .wdata  (bank_wdata[g]),
      .rdata  (bank_rdata[g])
    );
  end

  // Bank read stage
  rd_ctl_t b_ctl_r;
  logic    b_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en_b) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (bank_acc) begin
      b_ctl_r.is_read <= (a_op_r == OP_READ) && !a_err;
      b_ctl_r.sgn     <= a_sgn_r;
      b_ctl_r.big     <= a_big;
      b_ctl_r.size    <= a_size_r;
      b_ctl_r.lane    <= a_lane;
      b_err_r         <= a_err;
    end
  end

  logic [DATA_W-1:0] b_value;

  elsu_rd_align u_rd_align (
    .ctl       (b_ctl_r),
    .bank_data (bank_rdata),
    .value     (b_value)
  );

  // Result register
  logic [DATA_W-1:0] out_read_value_r;
  logic              out_range_error_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_c) begin
      out_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid_r && en_c) begin
      out_read_value_r  <= b_value;
      out_range_error_r <= b_err_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_read_value_r;
  assign out_range_error = out_range_error_r;

  // Checks
  a_no_write_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && a_err) |-> (bank_we == '0))
    else $error("bank written by an out-of-range access");

  a_accept_fills_a: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> a_valid_r)
    else $error("accepted item lost at input register");

  a_error_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_range_error) |-> (out_read_value == '0))
    else $error("range error result carries nonzero data");

  a_b_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && !en_b) |=> (b_valid_r && $stable(b_ctl_r)))
    else $error("bank read stage changed while stalled");

endmodule

// File: dv/elsu_access_checker.sv
`timescale 1ns / 1ps

// Watches both item channels and the register port of the load/store unit.
// Keeps a shadow byte store and order register, predicts the result of each
// accepted item and compares it with what comes out, in order.
module elsu_access_checker
  import elsu_pkg::*;
#(
  parameter int STORE_SIZE = STORE_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  in_operation,
  input  logic [IDX_W-1:0]      in_byte_index,
  input  logic [SIZE_W-1:0]     in_access_size,
  input  logic                  in_is_signed,
  input  logic [ORD_W-1:0]      in_byte_order,
  input  logic [DATA_W-1:0]     in_write_value,

  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [DATA_W-1:0]     out_read_value,
  input  logic                  out_range_error,

  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic [APB_DATA_W-1:0] prdata,
  input  logic                  pready,

  output int                    fail_count,
  output int                    outstanding
);

  typedef struct {
    logic [DATA_W-1:0] read_value;
    logic              range_error;
  } access_result_t;

  logic [BYTE_W-1:0] shadow_store [STORE_SIZE];
  logic              shadow_native_big;
  access_result_t    pending_results [$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("ERROR %0t ns: %s got 0x%h expected 0x%h", $time, what, got, want);
    fail_count++;
  endtask

  // Applies one access to the shadow store and returns the result it causes
  function automatic access_result_t apply_access(input op_t op,
                                                  input logic [IDX_W-1:0] idx,
                                                  input logic [SIZE_W-1:0] size,
                                                  input logic sgn,
                                                  input logic [ORD_W-1:0] ord,
                                                  input logic [DATA_W-1:0] wval);
    access_result_t res;
    int unsigned    nbytes;
    int unsigned    pos;
    logic           big;
    res.read_value  = '0;
    res.range_error = 1'b0;
    nbytes = 1 << size;
    if (int'(idx) + nbytes > STORE_SIZE) begin
      res.range_error = 1'b1;
      return res;
    end
    if (ord == ORD_LITTLE) big = 1'b0;
    else if (ord == ORD_BIG) big = 1'b1;
    else big = shadow_native_big;  // native and the spare code
    for (int unsigned k = 0; k < nbytes; k++) begin
      pos = big ? (nbytes - 1 - k) : k;
      if (op == OP_WRITE) shadow_store[int'(idx) + pos] = wval[k*8 +: 8];
      else res.read_value[k*8 +: 8] = shadow_store[int'(idx) + pos];
    end
    // sign-extend narrow reads
    if (op == OP_READ && sgn && nbytes < 8 && res.read_value[nbytes*8 - 1])
      res.read_value = res.read_value | ~((64'd1 << (nbytes * 8)) - 64'd1);
    return res;
  endfunction

  always @(posedge clk) begin
    access_result_t want;
    if (!rst_n) begin
      shadow_native_big = 1'b0;
      pending_results.delete();
    end else begin
      // register port: track writes, check reads
      if (psel && penable && pready && paddr == ADDR_NATIVE_IS_BIG) begin
        if (pwrite) shadow_native_big = pwdata[0];
        else if (prdata[0] !== shadow_native_big)
          report_mismatch("native order register read", 64'(prdata),
                          64'(shadow_native_big));
      end
      // result item
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result item, read_value", out_read_value, '0);
        end else begin
          want = pending_results.pop_front();
          if (out_read_value !== want.read_value)
            report_mismatch("read_value", out_read_value, want.read_value);
          if (out_range_error !== want.range_error)
            report_mismatch("range_error", 64'(out_range_error), 64'(want.range_error));
        end
      end
      // input item
      if (in_valid && in_ready)
        pending_results.push_back(apply_access(op_t'(in_operation), in_byte_index,
                                               in_access_size, in_is_signed,
                                               in_byte_order, in_write_value));
    end
    outstanding = pending_results.size();
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

// Drives directed and random accesses into the load/store unit in three
// throttling phases, flips the native byte order between phases, and gives
// the verdict from the checker's failure and outstanding counts.
module testbench;
  import elsu_pkg::*;

  localparam int STORE_SIZE = STORE_BYTES_DEF;
  localparam int PIPE_LAT   = 4;
  localparam int PHASE_ITEMS = 400;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_operation = OP_READ;
  logic [IDX_W-1:0]      in_byte_index = '0;
  logic [SIZE_W-1:0]     in_access_size = '0;
  logic                  in_is_signed = 1'b0;
  logic [ORD_W-1:0]      in_byte_order = ORD_LITTLE;
  logic [DATA_W-1:0]     in_write_value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [DATA_W-1:0]     out_read_value;
  logic                  out_range_error;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int fail_count;
  int outstanding;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int n_reads = 0;
  int n_writes = 0;
  int n_past_end = 0;
  int n_order_writes = 0;

  // bytes written so far; random reads that fit are only aimed at these
  bit written [STORE_SIZE];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  endian_byte_load_store_unit_core #(.STORE_BYTES(STORE_SIZE)) dut (.*);

  elsu_access_checker #(.STORE_SIZE(STORE_SIZE)) checker_i (.*);

  // receiver throttling
  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  initial begin
    #2_000_000;
    $display("Timeout waiting for the unit to finish");
    $display("Verification failed");
    $finish;
  end

  function automatic bit fits(input logic [IDX_W-1:0] idx, input logic [SIZE_W-1:0] size);
    return (int'(idx) + (1 << size)) <= STORE_SIZE;
  endfunction

  function automatic bit all_written(input logic [IDX_W-1:0] idx,
                                     input logic [SIZE_W-1:0] size);
    for (int k = 0; k < (1 << size); k++)
      if (!written[int'(idx) + k]) return 1'b0;
    return 1'b1;
  endfunction

  // Presents one item, starting and ending at a falling edge
  task automatic send_item(input op_t op, input logic [IDX_W-1:0] idx,
                           input logic [SIZE_W-1:0] size, input logic sgn,
                           input logic [ORD_W-1:0] ord, input logic [DATA_W-1:0] wval);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_byte_index  <= idx;
    in_access_size <= size;
    in_is_signed   <= sgn;
    in_byte_order  <= ord;
    in_write_value <= wval;
    if (!fits(idx, size)) n_past_end++;
    else if (op == OP_WRITE)
      for (int k = 0; k < (1 << size); k++) written[int'(idx) + k] = 1'b1;
    if (op == OP_WRITE) n_writes++;
    else n_reads++;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Holds the sender until every result is back, plus pipeline slack
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (PIPE_LAT) @(negedge clk);
  endtask

  // Setup then access cycle; pready is always high
  task automatic reg_access(input logic wr, input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_NATIVE_IS_BIG;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_native_order(input logic big);
    wait_idle();
    reg_access(1'b1, APB_DATA_W'(big));
    reg_access(1'b0, '0);
    n_order_writes++;
  endtask

  function automatic logic [IDX_W-1:0] pick_index();
    int r;
    r = $urandom_range(99);
    if (r < 50) return IDX_W'($urandom_range(127));
    if (r < 65) return IDX_W'(STORE_SIZE - $urandom_range(1, 12));
    return IDX_W'($urandom_range(STORE_SIZE - 1));
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(19))
      0: return '0;
      1: return '1;
      2: return 64'h8080_8080_8080_8080;
      3: return 64'h7f7f_7f7f_7f7f_7f7f;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Random access; reads land only on written bytes or past the end
  task automatic random_item();
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic [SIZE_W-1:0] size;
    int               tries;
    op    = ($urandom_range(99) < 45) ? OP_WRITE : OP_READ;
    size  = SIZE_W'($urandom_range(3));
    idx   = pick_index();
    tries = 0;
    while (op == OP_READ && fits(idx, size) && !all_written(idx, size)) begin
      tries++;
      if (tries > 8) op = OP_WRITE;
      else idx = pick_index();
    end
    send_item(op, idx, size, 1'($urandom), ORD_W'($urandom_range(3)), pick_value());
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (PHASE_ITEMS) random_item();
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    set_native_order(1'b0);

    // directed: full-width word, then narrow and signed views of it
    send_item(OP_WRITE, 12'd0, 2'd3, 1'b0, ORD_LITTLE, 64'h8877_6655_4433_2211);
    send_item(OP_READ,  12'd0, 2'd3, 1'b0, ORD_LITTLE, '0);
    send_item(OP_READ,  12'd0, 2'd3, 1'b1, ORD_BIG,    '0);
    send_item(OP_READ,  12'd7, 2'd0, 1'b1, ORD_LITTLE, '0);
    send_item(OP_READ,  12'd6, 2'd1, 1'b1, ORD_BIG,    '0);
    send_item(OP_READ,  12'd4, 2'd2, 1'b0, ORD_LITTLE, '0);
    send_item(OP_READ,  12'd4, 2'd2, 1'b1, ORD_LITTLE, '0);
    // unaligned big-endian write over the word
    send_item(OP_WRITE, 12'd3, 2'd2, 1'b0, ORD_BIG, 64'hFFFF_FFFF_DEAD_BEEF);
    send_item(OP_READ,  12'd0, 2'd3, 1'b0, ORD_LITTLE, '0);
    // last fitting word, native and spare order codes
    send_item(OP_WRITE, 12'd4088, 2'd3, 1'b0, ORD_BIG, 64'h8000_0000_0000_0001);
    send_item(OP_READ,  12'd4088, 2'd3, 1'b0, 2'd2, '0);
    send_item(OP_READ,  12'd4088, 2'd3, 1'b0, 2'd3, '0);
    // past the end, reads and writes, then a one-byte read of the last byte
    send_item(OP_WRITE, 12'd4093, 2'd2, 1'b0, ORD_LITTLE, '1);
    send_item(OP_READ,  12'd4089, 2'd3, 1'b0, ORD_LITTLE, '0);
    send_item(OP_WRITE, 12'd4095, 2'd1, 1'b1, ORD_BIG, '1);
    send_item(OP_READ,  12'd4095, 2'd0, 1'b1, ORD_LITTLE, '0);
    // last byte, sign flag on a write has no effect
    send_item(OP_WRITE, 12'd4095, 2'd0, 1'b1, 2'd3, 64'hFFFF_FFFF_FFFF_FFA5);
    send_item(OP_READ,  12'd4095, 2'd0, 1'b1, ORD_BIG, '0);
    send_item(OP_READ,  12'd4095, 2'd0, 1'b0, ORD_BIG, '0);
    send_item(OP_WRITE, 12'd100, 2'd1, 1'b1, 2'd2, 64'h0123_4567_89AB_80FF);
    send_item(OP_READ,  12'd100, 2'd1, 1'b1, ORD_LITTLE, '0);

    // native now means big endian
    set_native_order(1'b1);
    send_item(OP_READ,  12'd100, 2'd1, 1'b0, 2'd2, '0);
    send_item(OP_READ,  12'd0,   2'd2, 1'b1, 2'd3, '0);
    send_item(OP_WRITE, 12'd8,   2'd3, 1'b0, 2'd2, 64'hF0E1_D2C3_B4A5_9687);
    send_item(OP_READ,  12'd8,   2'd3, 1'b0, ORD_BIG, '0);

    // random phases: receiver idles more, then sender, then neither
    run_phase(33, 51);
    set_native_order(1'b0);
    run_phase(51, 33);
    set_native_order(1'b1);
    run_phase(0, 0);
    wait_idle();

    $display("Ran %0d reads and %0d writes, %0d of them past the end of the store,",
             n_reads, n_writes, n_past_end);
    $display("with %0d native byte order settings and three throttling phases.",
             n_order_writes);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
